### rtl/core/trm_pkg.sv
`timescale 1ns / 1ps

package trm_pkg;

   localparam int RUN_DEPTH = 1024;
   localparam int ADDR_W    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
   localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
   localparam int COORD_W   = 32;
   localparam int POINT_W   = 2 * COORD_W;

   localparam logic [1:0] ACT_CLEAR      = 2'd0;
   localparam logic [1:0] ACT_LOAD_LEFT  = 2'd1;
   localparam logic [1:0] ACT_LOAD_RIGHT = 2'd2;
   localparam logic [1:0] ACT_POP        = 2'd3;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  out_x;
      logic signed [COORD_W-1:0]  out_y;
      logic                       is_last;
      logic                       status;
   } rsp_word_type;

   typedef struct packed {
      logic clear_runs;
      logic load_left;
      logic load_right;
      logic read_heads;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } sts_type;

endpackage

### rtl/core/trm_ram.sv
`timescale 1ns / 1ps

module trm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/trm_ctrl.sv
`timescale 1ns / 1ps

module trm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_action,
   output logic             req_stall,
   input  trm_pkg::sts_type sts,
   output trm_pkg::cmd_type cmd
);

   import trm_pkg::*;

   localparam logic IDLE_ST = 1'b0;
   localparam logic POP_ST  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE_ST: begin
            if (req_valid) begin
               case (req_action)
                  ACT_CLEAR:      cmd.clear_runs = 1'b1;
                  ACT_LOAD_LEFT:  cmd.load_left  = 1'b1;
                  ACT_LOAD_RIGHT: cmd.load_right = 1'b1;
                  ACT_POP: begin
                     cmd.read_heads = 1'b1;
                     state_in       = POP_ST;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         POP_ST: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE_ST;
            end
         end
         default: state_in = IDLE_ST;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_ST;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE_ST);

endmodule

### rtl/core/trm_dpath.sv
`timescale 1ns / 1ps

module trm_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  trm_pkg::req_word_type req_word,
   input  trm_pkg::cmd_type      cmd,
   output trm_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output trm_pkg::rsp_word_type rsp_word
);

   import trm_pkg::*;

   logic [CNT_W-1:0]   left_count_ff, left_count_in;
   logic [CNT_W-1:0]   right_count_ff, right_count_in;
   logic [CNT_W-1:0]   left_read_ff, left_read_in;
   logic [CNT_W-1:0]   right_read_ff, right_read_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               left_wr, right_wr;
   logic [POINT_W-1:0] wr_point;
   logic [POINT_W-1:0] left_head, right_head;
   logic               have_l, have_r, take_left;
   logic [CNT_W-1:0]   left_read_nx, right_read_nx;

   assign wr_point = {req_word.point_x, req_word.point_y};
   assign left_wr  = cmd.load_left  && (left_count_ff  < CNT_W'(RUN_DEPTH));
   assign right_wr = cmd.load_right && (right_count_ff < CNT_W'(RUN_DEPTH));

   trm_ram #(.WIDTH(POINT_W), .DEPTH(RUN_DEPTH)) u_left_ram (
      .clock   (clock),
      .wr_en   (left_wr),
      .wr_addr (left_count_ff[ADDR_W-1:0]),
      .wr_data (wr_point),
      .rd_en   (cmd.read_heads),
      .rd_addr (left_read_ff[ADDR_W-1:0]),
      .rd_data (left_head)
   );

   trm_ram #(.WIDTH(POINT_W), .DEPTH(RUN_DEPTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (right_wr),
      .wr_addr (right_count_ff[ADDR_W-1:0]),
      .wr_data (wr_point),
      .rd_en   (cmd.read_heads),
      .rd_addr (right_read_ff[ADDR_W-1:0]),
      .rd_data (right_head)
   );

   assign have_l    = left_read_ff  < left_count_ff;
   assign have_r    = right_read_ff < right_count_ff;
   assign take_left = have_l && (!have_r ||
                      ($signed(left_head[POINT_W-1:COORD_W]) <
                       $signed(right_head[POINT_W-1:COORD_W])));

   assign left_read_nx  = left_read_ff  + CNT_W'(take_left);
   assign right_read_nx = right_read_ff + CNT_W'(have_r && !take_left);

   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      left_read_in   = left_read_ff;
      right_read_in  = right_read_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_word_in    = rsp_word_ff;

      if (cmd.clear_runs) begin
         left_count_in  = '0;
         right_count_in = '0;
         left_read_in   = '0;
         right_read_in  = '0;
      end
      if (left_wr) begin
         left_count_in = left_count_ff + CNT_W'(1);
      end
      if (right_wr) begin
         right_count_in = right_count_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (!have_l && !have_r) begin
            rsp_word_in = '0;
            rsp_word_in.status = 1'b1;
         end else begin
            left_read_in  = left_read_nx;
            right_read_in = right_read_nx;
            rsp_word_in.out_x = take_left ? $signed(left_head[POINT_W-1:COORD_W])
                                          : $signed(right_head[POINT_W-1:COORD_W]);
            rsp_word_in.out_y = take_left ? $signed(left_head[COORD_W-1:0])
                                          : $signed(right_head[COORD_W-1:0]);
            rsp_word_in.is_last = (left_read_nx >= left_count_ff) &&
                                  (right_read_nx >= right_count_ff);
            rsp_word_in.status  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff  <= '0;
         right_count_ff <= '0;
         left_read_ff   <= '0;
         right_read_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         left_read_ff   <= left_read_in;
         right_read_ff  <= right_read_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### rtl/core/two_run_merge_by_x_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Word
// req      in         req_valid/req_stall   action, point_x, point_y
// rsp      out        rsp_valid/rsp_stall   out_x, out_y, is_last, status
//
// Clear and load words leave the controller in IDLE_ST; a pop moves it to POP_ST,
// where the registered read of the two run RAMs feeds the head compare.
// A pop waits in POP_ST while the output register is full and stalled.
// Reset empties both runs; RAM contents are not cleared and need no clearing pass.
// A result waits in the output register while the next word is accepted.

module two_run_merge_by_x_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  trm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output trm_pkg::rsp_word_type rsp_word
);

   import trm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   trm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_word.action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   trm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import trm_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int X_MIN        = -2147483647 - 1;
   localparam int X_MAX        = 2147483647;

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type want;
   } steer_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   two_run_merge_by_x_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [COORD_W-1:0] left_px  [RUN_DEPTH];
   logic signed [COORD_W-1:0] left_py  [RUN_DEPTH];
   logic signed [COORD_W-1:0] right_px [RUN_DEPTH];
   logic signed [COORD_W-1:0] right_py [RUN_DEPTH];
   int left_fill, right_fill, left_taken, right_taken;

   rsp_word_type  merged_expect [$];
   steer_row_type steer_rows    [$];
   rsp_word_type  rsp_want;

   int send_idle_pct = 21;
   int stall_pct     = 82;
   int words_sent, points_merged, empty_pops, dropped_loads;
   int errors;
   int quiet_cycles;

   function automatic bit merge_predict(input req_word_type w, output rsp_word_type r);
      bit have_l, have_r, take_l;
      r = '0;
      case (w.action)
         ACT_CLEAR: begin
            left_fill = 0;
            right_fill = 0;
            left_taken = 0;
            right_taken = 0;
            return 1'b0;
         end
         ACT_LOAD_LEFT: begin
            if (left_fill < RUN_DEPTH) begin
               left_px[left_fill] = w.point_x;
               left_py[left_fill] = w.point_y;
               left_fill++;
            end else begin
               dropped_loads++;
            end
            return 1'b0;
         end
         ACT_LOAD_RIGHT: begin
            if (right_fill < RUN_DEPTH) begin
               right_px[right_fill] = w.point_x;
               right_py[right_fill] = w.point_y;
               right_fill++;
            end else begin
               dropped_loads++;
            end
            return 1'b0;
         end
         ACT_POP: begin
            have_l = left_taken < left_fill;
            have_r = right_taken < right_fill;
            if (!have_l && !have_r) begin
               r.status = 1'b1;
               empty_pops++;
               return 1'b1;
            end
            take_l = have_l && (!have_r || left_px[left_taken] < right_px[right_taken]);
            if (take_l) begin
               r.out_x = left_px[left_taken];
               r.out_y = left_py[left_taken];
               left_taken++;
            end else begin
               r.out_x = right_px[right_taken];
               r.out_y = right_py[right_taken];
               right_taken++;
            end
            r.is_last = (left_taken >= left_fill) && (right_taken >= right_fill);
            points_merged++;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
      return 1'b0;
   endfunction

   function automatic req_word_type make_word(logic [1:0] act, int x, int y);
      req_word_type w;
      w.action  = act;
      w.point_x = x;
      w.point_y = y;
      return w;
   endfunction

   function automatic int pick_coord(bit narrow);
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) return X_MIN;
      if (roll == 1) return X_MAX;
      if (narrow) return $urandom_range(0, 16) - 8;
      return $urandom;
   endfunction

   task automatic add_row(logic [1:0] act, int x, int y, bit typed,
                          int ex, int ey, bit last, bit st);
      steer_row_type row;
      row.w             = make_word(act, x, y);
      row.typed         = typed;
      row.want.out_x    = ex;
      row.want.out_y    = ey;
      row.want.is_last  = last;
      row.want.status   = st;
      steer_rows.insert(steer_rows.size(), row);
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
      errors++;
   endtask

   task automatic send_word(req_word_type w, bit typed, rsp_word_type typed_rsp);
      rsp_word_type r;
      bit           has_rsp;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_rsp = merge_predict(w, r);
      if (has_rsp) merged_expect.insert(merged_expect.size(), typed ? typed_rsp : r);
      words_sent++;
   endtask

   task automatic send_plain(req_word_type w);
      send_word(w, 1'b0, '0);
   endtask

   task automatic noise_word();
      send_plain(make_word(2'($urandom_range(0, 3)), $urandom, $urandom));
   endtask

   task automatic merge_set();
      int  xs_l [$];
      int  xs_r [$];
      int  nl, nr, npop, li, ri;
      bit  narrow, unsorted;
      nl       = $urandom_range(0, 12);
      nr       = $urandom_range(0, 12);
      narrow   = 1'($urandom_range(0, 1));
      unsorted = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < nl; i++) xs_l.insert(xs_l.size(), pick_coord(narrow));
      for (int i = 0; i < nr; i++) xs_r.insert(xs_r.size(), pick_coord(narrow));
      if (!unsorted) begin
         xs_l.sort();
         xs_r.sort();
      end
      send_plain(make_word(ACT_CLEAR, $urandom, $urandom));
      li = 0;
      ri = 0;
      while (li < nl || ri < nr) begin
         if (ri >= nr || (li < nl && $urandom_range(0, 1))) begin
            send_plain(make_word(ACT_LOAD_LEFT, xs_l[li], $urandom));
            li++;
         end else begin
            send_plain(make_word(ACT_LOAD_RIGHT, xs_r[ri], $urandom));
            ri++;
         end
      end
      npop = nl + nr + $urandom_range(0, 2);
      for (int i = 0; i < npop; i++) begin
         if ($urandom_range(0, 9) == 0) noise_word();
         send_plain(make_word(ACT_POP, $urandom, $urandom));
      end
   endtask

   task automatic fill_run(bit to_left);
      int xs [$];
      for (int i = 0; i < RUN_DEPTH + 2; i++) xs.insert(xs.size(), $urandom);
      xs.sort();
      send_plain(make_word(ACT_CLEAR, 0, 0));
      foreach (xs[i])
         send_plain(make_word(to_left ? ACT_LOAD_LEFT : ACT_LOAD_RIGHT, xs[i], $urandom));
      for (int i = 0; i < 3; i++)
         send_plain(make_word(to_left ? ACT_LOAD_RIGHT : ACT_LOAD_LEFT,
                              pick_coord(1'b0), $urandom));
      for (int i = 0; i < 24; i++) send_plain(make_word(ACT_POP, 0, 0));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (merged_expect.size() == 0) begin
            report_mismatch("unexpected word", rsp_word.out_x, '0);
         end else begin
            rsp_want = merged_expect.pop_front();
            if (rsp_word.out_x !== rsp_want.out_x)
               report_mismatch("out_x", rsp_word.out_x, rsp_want.out_x);
            if (rsp_word.out_y !== rsp_want.out_y)
               report_mismatch("out_y", rsp_word.out_y, rsp_want.out_y);
            if (rsp_word.is_last !== rsp_want.is_last)
               report_mismatch("is_last", 32'(rsp_word.is_last), 32'(rsp_want.is_last));
            if (rsp_word.status !== rsp_want.status)
               report_mismatch("status", 32'(rsp_word.status), 32'(rsp_want.status));
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      add_row(ACT_POP,        0,     0,     1, 0,     0,     0, 1);
      add_row(ACT_CLEAR,      X_MAX, X_MIN, 0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     1, 0,     0,     0, 1);
      add_row(ACT_LOAD_LEFT,  X_MIN, X_MAX, 0, 0,     0,     0, 0);
      add_row(ACT_LOAD_LEFT,  0,     -1,    0, 0,     0,     0, 0);
      add_row(ACT_LOAD_LEFT,  5,     1,     0, 0,     0,     0, 0);
      add_row(ACT_LOAD_RIGHT, X_MIN, 0,     0, 0,     0,     0, 0);
      add_row(ACT_LOAD_RIGHT, 5,     2,     0, 0,     0,     0, 0);
      add_row(ACT_LOAD_RIGHT, X_MAX, X_MIN, 0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     1, X_MIN, 0,     0, 0);
      add_row(ACT_POP,        -1,    -1,    0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     0, 0,     0,     0, 0);
      add_row(ACT_LOAD_LEFT,  3,     7,     0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     1, X_MAX, X_MIN, 1, 0);
      add_row(ACT_POP,        0,     0,     1, 0,     0,     0, 1);
      add_row(ACT_LOAD_LEFT,  -1,    9,     0, 0,     0,     0, 0);
      add_row(ACT_CLEAR,      -1,    -1,    0, 0,     0,     0, 0);
      add_row(ACT_POP,        0,     0,     1, 0,     0,     0, 1);
      add_row(ACT_LOAD_RIGHT, -7,    X_MAX, 0, 0,     0,     0, 0);
      add_row(ACT_POP,        X_MAX, X_MIN, 1, -7,    X_MAX, 1, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (steer_rows[i]) send_word(steer_rows[i].w, steer_rows[i].typed, steer_rows[i].want);

      while (words_sent < 300) merge_set();
      fill_run(1'b0);

      send_idle_pct = 82;
      stall_pct     = 21;
      while (words_sent < 1600) merge_set();

      send_idle_pct = 0;
      stall_pct     = 0;
      while (words_sent < 1900) merge_set();

      req_valid <= 1'b0;
      while (merged_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words sent: %0d points merged, %0d pops on empty runs,",
               words_sent, points_merged, empty_pops);
      $display("%0d loads dropped on full runs, %0d mismatches", dropped_loads, errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
